FILE: sv/bcs_pkg.sv
// Shared types and constants for the binned count standard deviation block.
package bcs_pkg;

   localparam int BIN_SIZE_W   = 11;
   localparam int BIN_SIZE_LOG = 10;
   localparam int BIN_SIZE_MAX = 1024;
   localparam int BIN_SIZE_RST = 10;
   localparam int STDEV_W      = 26;
   localparam int BINS_USED_W  = 17;
   localparam int FRAC_BITS    = 8;
   localparam int FRAC_SHIFT   = 2 * FRAC_BITS;

   localparam logic [STDEV_W-1:0] STDEV_MAX = {STDEV_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_SETTLE,
      ST_LOAD_SQ,
      ST_MUL_SQ,
      ST_LOAD_SUM,
      ST_MUL_SUM,
      ST_LOAD_DIV,
      ST_DIV,
      ST_LOAD_ROOT,
      ST_ROOT,
      ST_DONE
   } bcs_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_SQ,
      OP_MUL_ADD,
      OP_LOAD_SUM,
      OP_MUL_SUB,
      OP_LOAD_DIV,
      OP_DIV_STEP,
      OP_LOAD_ROOT,
      OP_ROOT_STEP
   } bcs_op_type;

   typedef struct packed {
      logic       take;
      bcs_op_type op;
      logic       emit;
   } bcs_cmd_type;

   typedef struct packed {
      logic no_bins;
      logic step_last;
   } bcs_status_type;

endpackage

FILE: sv/binned_count_stdev.sv
// Throughput: one sample request per cycle; a request without end_of_run yields no response.
// An end_of_run request is answered once the bin pipeline drains and the bit-serial multiply,
// divide and root steps finish; with no complete bin those steps are skipped.
// Requests stall while a response is being computed; config writes are taken at any time.
// Reset (synchronous, active high) clears all run state and sets bin_size to 10.
module binned_count_stdev #(
   parameter int MAX_BINS     = 65536,
   parameter int SAMPLE_WIDTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel: one count sample per request
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SAMPLE_WIDTH-1:0]            req_sample,
   input  logic                               req_end_of_run,
   // response channel: one statistic per run
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bcs_pkg::STDEV_W-1:0]        rsp_stdev_fixed,
   output logic [bcs_pkg::BINS_USED_W-1:0]    rsp_bins_used,
   output logic                               rsp_empty_res,
   // bin size register
   input  logic                               csr_wr_en,
   input  logic [bcs_pkg::BIN_SIZE_W-1:0]     csr_wr_data
);

   // The controller walks the run-end sequence: drain the bin pipeline, form
   // n*sumsq - sum^2 with a shift-add multiplier, divide by n^2 one quotient
   // bit a cycle, then take the integer square root two bits a cycle.
   bcs_pkg::bcs_cmd_type    cmd;
   bcs_pkg::bcs_status_type status;

   bcs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_end_of_run (req_end_of_run),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   // The datapath holds the bin accumulators and all arithmetic registers;
   // the response payload sits in its output register until taken.
   bcs_datapath #(
      .MAX_BINS     (MAX_BINS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_stdev_fixed (rsp_stdev_fixed),
      .rsp_bins_used   (rsp_bins_used),
      .rsp_empty_res   (rsp_empty_res)
   );

endmodule

FILE: sv/bcs_ctrl.sv
// Sequencer for the binned count standard deviation block: handshakes and step order.
module bcs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_end_of_run,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  bcs_pkg::bcs_status_type status,
   output bcs_pkg::bcs_cmd_type    cmd
);

   bcs_pkg::bcs_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.take  = 1'b0;
      cmd.op    = bcs_pkg::OP_NONE;
      cmd.emit  = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         bcs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
            if (req_valid && req_end_of_run) begin
               state_in = bcs_pkg::ST_FLUSH;
            end
         end
         bcs_pkg::ST_FLUSH: begin
            state_in = bcs_pkg::ST_SETTLE;
         end
         bcs_pkg::ST_SETTLE: begin
            state_in = bcs_pkg::ST_LOAD_SQ;
         end
         bcs_pkg::ST_LOAD_SQ: begin
            if (status.no_bins) begin
               state_in = bcs_pkg::ST_DONE;
            end else begin
               cmd.op   = bcs_pkg::OP_LOAD_SQ;
               state_in = bcs_pkg::ST_MUL_SQ;
            end
         end
         bcs_pkg::ST_MUL_SQ: begin
            cmd.op = bcs_pkg::OP_MUL_ADD;
            if (status.step_last) begin
               state_in = bcs_pkg::ST_LOAD_SUM;
            end
         end
         bcs_pkg::ST_LOAD_SUM: begin
            cmd.op   = bcs_pkg::OP_LOAD_SUM;
            state_in = bcs_pkg::ST_MUL_SUM;
         end
         bcs_pkg::ST_MUL_SUM: begin
            cmd.op = bcs_pkg::OP_MUL_SUB;
            if (status.step_last) begin
               state_in = bcs_pkg::ST_LOAD_DIV;
            end
         end
         bcs_pkg::ST_LOAD_DIV: begin
            cmd.op   = bcs_pkg::OP_LOAD_DIV;
            state_in = bcs_pkg::ST_DIV;
         end
         bcs_pkg::ST_DIV: begin
            cmd.op = bcs_pkg::OP_DIV_STEP;
            if (status.step_last) begin
               state_in = bcs_pkg::ST_LOAD_ROOT;
            end
         end
         bcs_pkg::ST_LOAD_ROOT: begin
            cmd.op   = bcs_pkg::OP_LOAD_ROOT;
            state_in = bcs_pkg::ST_ROOT;
         end
         bcs_pkg::ST_ROOT: begin
            cmd.op = bcs_pkg::OP_ROOT_STEP;
            if (status.step_last) begin
               state_in = bcs_pkg::ST_DONE;
            end
         end
         bcs_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = bcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcs_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/bcs_datapath.sv
// Datapath: bin accumulation, shift-add multiplier, restoring divider and square root.
module bcs_datapath #(
   parameter int MAX_BINS     = 65536,
   parameter int SAMPLE_WIDTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bcs_pkg::bcs_cmd_type                 cmd,
   output bcs_pkg::bcs_status_type              status,
   input  logic [SAMPLE_WIDTH-1:0]              req_sample,
   input  logic                                 csr_wr_en,
   input  logic [bcs_pkg::BIN_SIZE_W-1:0]       csr_wr_data,
   output logic [bcs_pkg::STDEV_W-1:0]          rsp_stdev_fixed,
   output logic [bcs_pkg::BINS_USED_W-1:0]      rsp_bins_used,
   output logic                                 rsp_empty_res
);

   localparam int ACC_W  = SAMPLE_WIDTH + bcs_pkg::BIN_SIZE_LOG;
   localparam int CNT_W  = $clog2(MAX_BINS + 1);
   localparam int LOG_B  = $clog2(MAX_BINS);
   localparam int SUM_W  = ACC_W + LOG_B;
   localparam int SQ_W   = 2 * ACC_W + LOG_B;
   localparam int D_W    = CNT_W + SQ_W;
   localparam int DV_W   = 2 * CNT_W;
   localparam int N_W    = D_W + bcs_pkg::FRAC_SHIFT;
   localparam int Q_W    = 2 * ACC_W + bcs_pkg::FRAC_SHIFT - 2;
   localparam int QE_W   = Q_W + (Q_W % 2);
   localparam int R_W    = QE_W / 2;
   localparam int STEP_W = $clog2(N_W + 1);
   localparam int BS_W   = bcs_pkg::BIN_SIZE_W;

   // configuration and run state
   logic [BS_W-1:0]       bin_size_ff, bin_size_in;
   logic [ACC_W-1:0]      bin_accum_ff, bin_accum_in;
   logic [BS_W-1:0]       bin_fill_ff, bin_fill_in;
   logic [SUM_W-1:0]      total_sum_ff, total_sum_in;
   logic [SQ_W-1:0]       total_sum_sq_ff, total_sum_sq_in;
   logic [CNT_W-1:0]      bins_done_ff, bins_done_in;
   logic                  pend_ff, pend_in;
   logic                  sq_pend_ff, sq_pend_in;
   logic [ACC_W-1:0]      tot_ff, tot_in;
   logic [2*ACC_W-1:0]    sqv_ff, sqv_in;

   // arithmetic working registers
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [D_W-1:0]        acc_ff, acc_in;
   logic [D_W-1:0]        mcand_ff, mcand_in;
   logic [SUM_W-1:0]      mplier_ff, mplier_in;
   logic [DV_W-1:0]       div_ff, div_in;
   logic [DV_W-1:0]       rem_ff, rem_in;
   logic [N_W-1:0]        nq_ff, nq_in;
   logic [QE_W-1:0]       x_ff, x_in;
   logic [QE_W-1:0]       res_ff, res_in;
   logic [QE_W-1:0]       bit_ff, bit_in;

   logic [bcs_pkg::STDEV_W-1:0]     stdev_ff, stdev_in;
   logic [bcs_pkg::BINS_USED_W-1:0] used_ff, used_in;
   logic                            empty_ff, empty_in;

   logic [BS_W-1:0]       size;
   logic [BS_W-1:0]       fill_next;
   logic [ACC_W-1:0]      accum_next;
   logic                  sub;
   logic [DV_W:0]         trial;
   logic                  ge;
   logic [QE_W-1:0]       root_t;
   logic                  no_bins;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff     <= BS_W'(bcs_pkg::BIN_SIZE_RST);
         bin_accum_ff    <= '0;
         bin_fill_ff     <= '0;
         total_sum_ff    <= '0;
         total_sum_sq_ff <= '0;
         bins_done_ff    <= '0;
         pend_ff         <= 1'b0;
         sq_pend_ff      <= 1'b0;
         step_ff         <= '0;
      end else begin
         bin_size_ff     <= bin_size_in;
         bin_accum_ff    <= bin_accum_in;
         bin_fill_ff     <= bin_fill_in;
         total_sum_ff    <= total_sum_in;
         total_sum_sq_ff <= total_sum_sq_in;
         bins_done_ff    <= bins_done_in;
         pend_ff         <= pend_in;
         sq_pend_ff      <= sq_pend_in;
         step_ff         <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      tot_ff    <= tot_in;
      sqv_ff    <= sqv_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      nq_ff     <= nq_in;
      x_ff      <= x_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      stdev_ff  <= stdev_in;
      used_ff   <= used_in;
      empty_ff  <= empty_in;
   end

   assign no_bins = (bins_done_ff == '0);

   always_comb begin
      if (bin_size_ff == '0) begin
         size = BS_W'(1);
      end else if (bin_size_ff > BS_W'(bcs_pkg::BIN_SIZE_MAX)) begin
         size = BS_W'(bcs_pkg::BIN_SIZE_MAX);
      end else begin
         size = bin_size_ff;
      end
      fill_next  = bin_fill_ff + BS_W'(1);
      accum_next = bin_accum_ff + ACC_W'(req_sample);

      bin_size_in     = csr_wr_en ? csr_wr_data : bin_size_ff;
      bin_accum_in    = bin_accum_ff;
      bin_fill_in     = bin_fill_ff;
      total_sum_in    = total_sum_ff;
      total_sum_sq_in = total_sum_sq_ff;
      bins_done_in    = bins_done_ff;
      pend_in         = 1'b0;
      sq_pend_in      = 1'b0;
      tot_in          = tot_ff;
      sqv_in          = sqv_ff;

      // bin totals drain through two stages: add to the sum and square, then add the square
      if (pend_ff) begin
         total_sum_in = total_sum_ff + SUM_W'(tot_ff);
         sqv_in       = (2 * ACC_W)'(tot_ff) * (2 * ACC_W)'(tot_ff);
         sq_pend_in   = 1'b1;
      end
      if (sq_pend_ff) begin
         total_sum_sq_in = total_sum_sq_ff + SQ_W'(sqv_ff);
      end

      if (cmd.take) begin
         if (fill_next >= size) begin
            if (bins_done_ff < CNT_W'(MAX_BINS)) begin
               tot_in       = accum_next;
               pend_in      = 1'b1;
               bins_done_in = bins_done_ff + CNT_W'(1);
            end
            bin_accum_in = '0;
            bin_fill_in  = '0;
         end else begin
            bin_accum_in = accum_next;
            bin_fill_in  = fill_next;
         end
      end

      step_in   = step_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      nq_in     = nq_ff;
      x_in      = x_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      sub       = (cmd.op == bcs_pkg::OP_MUL_SUB);
      trial     = {rem_ff, nq_ff[N_W-1]};
      ge        = (trial >= {1'b0, div_ff});
      root_t    = res_ff + bit_ff;

      case (cmd.op)
         bcs_pkg::OP_LOAD_SQ: begin
            acc_in    = '0;
            mcand_in  = D_W'(total_sum_sq_ff);
            mplier_in = SUM_W'(bins_done_ff);
            div_in    = DV_W'(bins_done_ff) * DV_W'(bins_done_ff);
            step_in   = STEP_W'(CNT_W);
         end
         bcs_pkg::OP_LOAD_SUM: begin
            mcand_in  = D_W'(total_sum_ff);
            mplier_in = total_sum_ff;
            step_in   = STEP_W'(SUM_W);
         end
         bcs_pkg::OP_MUL_ADD, bcs_pkg::OP_MUL_SUB: begin
            // add or subtract the shifted multiplicand; wraparound cancels at the end
            if (mplier_ff[0]) begin
               acc_in = acc_ff + (mcand_ff ^ {D_W{sub}}) + D_W'(sub);
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - STEP_W'(1);
         end
         bcs_pkg::OP_LOAD_DIV: begin
            nq_in   = {acc_ff, {bcs_pkg::FRAC_SHIFT{1'b0}}};
            rem_in  = '0;
            step_in = STEP_W'(N_W);
         end
         bcs_pkg::OP_DIV_STEP: begin
            if (ge) begin
               rem_in = DV_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = DV_W'(trial);
            end
            nq_in   = {nq_ff[N_W-2:0], ge};
            step_in = step_ff - STEP_W'(1);
         end
         bcs_pkg::OP_LOAD_ROOT: begin
            x_in    = QE_W'(nq_ff[Q_W-1:0]);
            res_in  = '0;
            bit_in  = QE_W'(1) << (QE_W - 2);
            step_in = STEP_W'(R_W);
         end
         bcs_pkg::OP_ROOT_STEP: begin
            if (x_ff >= root_t) begin
               x_in   = x_ff - root_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff - STEP_W'(1);
         end
         default: begin
         end
      endcase

      stdev_in = stdev_ff;
      used_in  = used_ff;
      empty_in = empty_ff;
      if (cmd.emit) begin
         if (no_bins) begin
            stdev_in = '0;
         end else if (res_ff > QE_W'(bcs_pkg::STDEV_MAX)) begin
            stdev_in = bcs_pkg::STDEV_MAX;
         end else begin
            stdev_in = bcs_pkg::STDEV_W'(res_ff);
         end
         used_in  = bcs_pkg::BINS_USED_W'(bins_done_ff);
         empty_in = no_bins;
         // start the next run from a clean slate
         bin_accum_in    = '0;
         bin_fill_in     = '0;
         total_sum_in    = '0;
         total_sum_sq_in = '0;
         bins_done_in    = '0;
      end
   end

   assign status.no_bins   = no_bins;
   assign status.step_last = (step_ff == STEP_W'(1));

   assign rsp_stdev_fixed = stdev_ff;
   assign rsp_bins_used   = used_ff;
   assign rsp_empty_res   = empty_ff;

endmodule
